// ----- design/dmcs_pkg.sv -----
package dmcs_pkg;

    // request codes
    localparam logic REQ_LOAD    = 1'b0;
    localparam logic REQ_ADVANCE = 1'b1;

    // transfer modes
    localparam logic [1:0] MODE_CONTIG    = 2'd0;
    localparam logic [1:0] MODE_PER_PLANE = 2'd1;
    localparam logic [1:0] MODE_PER_ROW   = 2'd2;
    localparam logic [1:0] MODE_TRANSPOSE = 2'd3;

    // one request item
    typedef struct packed {
        logic        req_type;
        logic [31:0] ext_base;
        logic [31:0] loc_base;
        logic [15:0] row_length;
        logic [31:0] row_stride;
        logic [31:0] plane_stride;
        logic [15:0] rows_per_plane;
        logic [15:0] plane_count;
        logic        direction;
        logic        chan_transpose;
    } req_item_t;

    // one command item
    typedef struct packed {
        logic        no_command;
        logic        last_command;
        logic [31:0] cmd_ext_addr;
        logic [31:0] cmd_loc_addr;
        logic [31:0] cmd_length;
        logic        cmd_strided;
        logic [31:0] cmd_elem_stride;
        logic        cmd_direction;
        logic [1:0]  transfer_mode;
    } cmd_item_t;

endpackage

// ----- design/dma_multidim_copy_splitter_unit.sv -----
// cmd_valid rises when EMIT registers a command: an advance goes from IDLE straight to
// EMIT, a contiguous or per-plane load first runs the RL, RP and RLP products, a per-row
// or transpose load six passes through the shared registered 32x16 multiplier and one
// reciprocal divide. One item at a time: req_ready returns as the command is registered;
// EMIT stalls until the old command is taken; a new item is taken while the old one waits
// reset: asynchronous active low, no command pending, core_index cleared to 0
module dma_multidim_copy_splitter_unit
    import dmcs_pkg::*;
#(
    parameter int CORE_COUNT = 8
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  req_item_t  req,
    output logic       cmd_valid,
    input  logic       cmd_ready,
    output cmd_item_t  cmd,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_RL,
        ST_MUL_RP,
        ST_MUL_RLP,
        ST_DECIDE,
        ST_DIV_WAIT,
        ST_MUL_START,
        ST_CLAMP,
        ST_MUL_OFF,
        ST_MUL_OFF2,
        ST_ADD_LOC,
        ST_EMIT
    } state_t;

    state_t      state_reg;
    logic [2:0]  core_index_reg;
    logic        active_reg;
    logic [1:0]  mode_reg;
    logic [15:0] outer_reg;
    logic [15:0] inner_reg;
    logic [15:0] stop_reg;
    logic [31:0] cur_ext_reg;
    logic [31:0] row_base_reg;
    logic [31:0] cur_loc_reg;
    logic [15:0] per_reg;

    // descriptor
    logic [15:0] len_reg;
    logic [31:0] rstr_reg;
    logic [31:0] pstr_reg;
    logic [15:0] rows_reg;
    logic [15:0] planes_reg;
    logic        dir_reg;
    logic        hwc_reg;
    logic [31:0] rl_reg;
    logic [31:0] rp_reg;
    logic [31:0] rlp_reg;

    cmd_item_t   cmd_reg;
    cmd_item_t   cmd_next;
    logic        cmd_valid_reg;

    logic [31:0] mul_a;
    logic [15:0] mul_b;
    logic [31:0] prod;
    logic        div_start;
    logic        div_done;
    logic [15:0] div_q;
    logic [15:0] share_n;
    logic [15:0] share_dec;
    logic [1:0]  mode_dec;
    logic        emit_go;
    logic [15:0] clamp_start;
    logic [16:0] clamp_end;
    logic [15:0] clamp_stop;

    // emit-side next state
    logic        active_next;
    logic [15:0] outer_next;
    logic [15:0] inner_next;
    logic [31:0] cur_ext_next;
    logic [31:0] row_base_next;
    logic [31:0] cur_loc_next;

    assign req_ready = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;
    assign emit_go   = (state_reg == ST_EMIT) && (!cmd_valid_reg || cmd_ready);

    // mode choice from the captured descriptor
    always_comb
    begin
        if (hwc_reg)
            mode_dec = MODE_TRANSPOSE;
        else if (rl_reg == pstr_reg || (rows_reg == 16'd1 && planes_reg == 16'd1))
            mode_dec = MODE_CONTIG;
        else if ({16'd0, len_reg} == rstr_reg)
            mode_dec = MODE_PER_PLANE;
        else
            mode_dec = MODE_PER_ROW;
    end

    assign share_n   = (mode_reg == MODE_PER_ROW) ? planes_reg : len_reg;
    assign share_dec = (mode_dec == MODE_PER_ROW) ? planes_reg : len_reg;
    assign div_start = (state_reg == ST_DECIDE) &&
                       (mode_dec == MODE_PER_ROW || mode_dec == MODE_TRANSPOSE);

    // core share bounds
    assign clamp_start = (prod > {16'd0, share_n}) ? share_n : prod[15:0];
    assign clamp_end   = {1'b0, clamp_start} + {1'b0, per_reg};
    assign clamp_stop  = (clamp_end > {1'b0, share_n}) ? share_n : clamp_end[15:0];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 16'd0;
        unique case (state_reg)
            ST_MUL_RL:
            begin
                mul_a = {16'd0, rows_reg};
                mul_b = len_reg;
            end
            ST_MUL_RP:
            begin
                mul_a = {16'd0, rows_reg};
                mul_b = planes_reg;
            end
            ST_MUL_RLP:
            begin
                mul_a = rl_reg;
                mul_b = planes_reg;
            end
            ST_MUL_START:
            begin
                mul_a = {16'd0, per_reg};
                mul_b = {13'd0, core_index_reg};
            end
            ST_MUL_OFF:
            begin
                mul_a = pstr_reg;
                mul_b = outer_reg;
            end
            ST_MUL_OFF2:
            begin
                mul_a = (mode_reg == MODE_PER_ROW) ? rl_reg : rp_reg;
                mul_b = outer_reg;
            end
            default:
            begin
                mul_a = 32'd0;
                mul_b = 16'd0;
            end
        endcase
    end

    dmcs_mul u_mul (
        .clk     (clk),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod)
    );

    dmcs_cdiv #(
        .DIVISOR (CORE_COUNT)
    ) u_cdiv (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (share_dec),
        .done     (div_done),
        .quotient (div_q)
    );

    // command for the current position and the position after it
    always_comb
    begin
        cmd_next      = '0;
        active_next   = active_reg;
        outer_next    = outer_reg;
        inner_next    = inner_reg;
        cur_ext_next  = cur_ext_reg;
        row_base_next = row_base_reg;
        cur_loc_next  = cur_loc_reg;
        if (!active_reg)
        begin
            cmd_next.no_command = 1'b1;
        end
        else
        begin
            cmd_next.cmd_ext_addr  = cur_ext_reg;
            cmd_next.cmd_loc_addr  = cur_loc_reg;
            cmd_next.cmd_direction = dir_reg;
            cmd_next.transfer_mode = mode_reg;
            unique case (mode_reg)
                MODE_CONTIG:
                begin
                    cmd_next.cmd_length = rlp_reg;
                    active_next         = 1'b0;
                end
                MODE_PER_PLANE:
                begin
                    cmd_next.cmd_length = rl_reg;
                    cur_loc_next        = cur_loc_reg + rl_reg;
                    cur_ext_next        = cur_ext_reg + pstr_reg;
                    outer_next          = outer_reg + 16'd1;
                    active_next         = (outer_next < stop_reg);
                end
                MODE_PER_ROW:
                begin
                    cmd_next.cmd_length = {16'd0, len_reg};
                    cur_loc_next        = cur_loc_reg + {16'd0, len_reg};
                    cur_ext_next        = cur_ext_reg + rstr_reg;
                    inner_next          = inner_reg + 16'd1;
                    if (inner_next >= rows_reg)
                    begin
                        inner_next    = 16'd0;
                        outer_next    = outer_reg + 16'd1;
                        row_base_next = row_base_reg + pstr_reg;
                        cur_ext_next  = row_base_next;
                        active_next   = (outer_next < stop_reg);
                    end
                end
                default:
                begin
                    cmd_next.cmd_length      = rp_reg;
                    cmd_next.cmd_strided     = 1'b1;
                    cmd_next.cmd_elem_stride = rstr_reg;
                    cur_loc_next             = cur_loc_reg + rp_reg;
                    cur_ext_next             = cur_ext_reg + 32'd1;
                    outer_next               = outer_reg + 16'd1;
                    active_next              = (outer_next < stop_reg);
                end
            endcase
            cmd_next.last_command = !active_next;
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            core_index_reg <= 3'd0;
        else if (cfg_valid)
            core_index_reg <= cfg_data;
    end

    // descriptor capture and derived products
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && req_valid && req.req_type == REQ_LOAD)
        begin
            len_reg    <= req.row_length;
            rstr_reg   <= req.row_stride;
            pstr_reg   <= req.plane_stride;
            rows_reg   <= req.rows_per_plane;
            planes_reg <= req.plane_count;
            dir_reg    <= req.direction;
            hwc_reg    <= req.chan_transpose;
        end
        if (state_reg == ST_MUL_RP)
            rl_reg <= prod;
        if (state_reg == ST_MUL_RLP)
            rp_reg <= prod;
        if (state_reg == ST_DECIDE)
            rlp_reg <= prod;
        if (state_reg == ST_DIV_WAIT && div_done)
            per_reg <= div_q;
        if (emit_go)
            cmd_reg <= cmd_next;
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            active_reg    <= 1'b0;
            mode_reg      <= MODE_CONTIG;
            outer_reg     <= 16'd0;
            inner_reg     <= 16'd0;
            stop_reg      <= 16'd0;
            cur_ext_reg   <= 32'd0;
            row_base_reg  <= 32'd0;
            cur_loc_reg   <= 32'd0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            // output holds until taken, a new command replaces a taken one
            if (emit_go)
                cmd_valid_reg <= 1'b1;
            else if (cmd_valid_reg && cmd_ready)
                cmd_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (req_valid)
                    begin
                        if (req.req_type == REQ_LOAD)
                        begin
                            cur_ext_reg  <= req.ext_base;
                            row_base_reg <= req.ext_base;
                            cur_loc_reg  <= req.loc_base;
                            state_reg    <= ST_MUL_RL;
                        end
                        else
                        begin
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_MUL_RL:
                    state_reg <= ST_MUL_RP;
                ST_MUL_RP:
                    state_reg <= ST_MUL_RLP;
                ST_MUL_RLP:
                    state_reg <= ST_DECIDE;
                ST_DECIDE:
                begin
                    mode_reg  <= mode_dec;
                    outer_reg <= 16'd0;
                    inner_reg <= 16'd0;
                    unique case (mode_dec)
                        MODE_CONTIG:
                        begin
                            stop_reg   <= 16'd1;
                            active_reg <= (core_index_reg == 3'd0);
                            state_reg  <= ST_EMIT;
                        end
                        MODE_PER_PLANE:
                        begin
                            stop_reg   <= planes_reg;
                            active_reg <= (core_index_reg == 3'd0) && (planes_reg != 16'd0);
                            state_reg  <= ST_EMIT;
                        end
                        default:
                        begin
                            active_reg <= 1'b0;
                            state_reg  <= ST_DIV_WAIT;
                        end
                    endcase
                end
                ST_DIV_WAIT:
                begin
                    if (div_done)
                        state_reg <= ST_MUL_START;
                end
                ST_MUL_START:
                    state_reg <= ST_CLAMP;
                ST_CLAMP:
                begin
                    outer_reg <= clamp_start;
                    stop_reg  <= clamp_stop;
                    state_reg <= ST_MUL_OFF;
                end
                ST_MUL_OFF:
                    state_reg <= ST_MUL_OFF2;
                ST_MUL_OFF2:
                begin
                    // prod holds plane_stride times start
                    if (mode_reg == MODE_PER_ROW)
                    begin
                        cur_ext_reg  <= cur_ext_reg + prod;
                        row_base_reg <= cur_ext_reg + prod;
                    end
                    else
                    begin
                        cur_ext_reg <= cur_ext_reg + {16'd0, outer_reg};
                    end
                    state_reg <= ST_ADD_LOC;
                end
                ST_ADD_LOC:
                begin
                    cur_loc_reg <= cur_loc_reg + prod;
                    active_reg  <= (outer_reg < stop_reg) &&
                                   (mode_reg == MODE_TRANSPOSE || rows_reg != 16'd0);
                    state_reg   <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        active_reg   <= active_next;
                        outer_reg    <= outer_next;
                        inner_reg    <= inner_next;
                        cur_ext_reg  <= cur_ext_next;
                        row_base_reg <= row_base_next;
                        cur_loc_reg  <= cur_loc_next;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ----- design/dmcs_mul.sv -----
module dmcs_mul
    import dmcs_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [15:0] b,
    output logic [31:0] product
);

    logic [47:0] full_product;
    logic [31:0] product_reg;

    // 32x16 multiply, low word kept, registered
    assign full_product = a * b;

    always_ff @(posedge clk)
    begin
        product_reg <= full_product[31:0];
    end

    assign product = product_reg;

endmodule

// ----- design/dmcs_cdiv.sv -----
module dmcs_cdiv
    import dmcs_pkg::*;
#(
    parameter int DIVISOR = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    output logic        done,
    output logic [15:0] quotient
);

    // 17-bit numerator plus 4 guard bits keeps the floor exact for divisors up to 16
    localparam int          SHIFT = 21;
    localparam logic [21:0] RECIP =
        22'(((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR));

    logic [16:0] num_reg;
    logic        done_reg;
    logic [38:0] scaled;

    // done is registered from start, so the quotient is ready in the cycle after start
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= start;
    end

    // ceiling by pre-adding divisor minus one
    always_ff @(posedge clk)
    begin
        if (start)
            num_reg <= {1'b0, dividend} + 17'(DIVISOR - 1);
    end

    // floor through the constant reciprocal
    assign scaled   = {22'd0, num_reg} * {17'd0, RECIP};
    assign done     = done_reg;
    assign quotient = scaled[SHIFT+15:SHIFT];

endmodule
